[rtl/lpfc_pkg.sv]
// Shared types and constants for the length-prefixed frame checker.
package lpfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0] CrcPoly = 8'h8C;
  localparam logic [ByteW-1:0] CrcInit = 8'h00;
  localparam logic [ByteW-1:0] MinFrameLen = 8'd5;
  localparam logic [ByteW-1:0] MaxFrameLenReset = 8'd20;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_TOO_SHORT = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_BAD_CRC   = 2'd3
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] byte_index;
    logic             frame_end;
    status_e          status;
  } res_t;

endpackage

[rtl/lpfc_rx_if.sv]
// Valid/ready channel that carries received bytes into the checker.
interface lpfc_rx_if;
  import lpfc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/lpfc_res_if.sv]
// Valid/ready channel that carries one checked result per received byte.
interface lpfc_res_if;
  import lpfc_pkg::*;

  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   data_byte;
  logic [ByteW-1:0]   byte_index;
  logic               frame_end;
  logic [StatusW-1:0] status;

  modport source (output valid, output data_byte, output byte_index, output frame_end,
                  output status, input ready);
  modport sink (input valid, input data_byte, input byte_index, input frame_end,
                input status, output ready);
endinterface

[rtl/lpfc_crc8.sv]
// One-byte update of the reflected CRC-8 (polynomial 0x8C), unrolled into XOR logic.
module lpfc_crc8 (
  input  logic [lpfc_pkg::ByteW-1:0] crc_i,
  input  logic [lpfc_pkg::ByteW-1:0] data_i,
  output logic [lpfc_pkg::ByteW-1:0] crc_o
);
  import lpfc_pkg::*;

  // Eight shift steps, LSB first; each step is a single XOR layer.
  always_comb begin
    logic [ByteW-1:0] c;
    logic [ByteW-1:0] v;
    c = crc_i;
    v = data_i;
    for (int i = 0; i < ByteW; i++) begin
      if (c[0] ^ v[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
      v = v >> 1;
    end
    crc_o = c;
  end
endmodule

[rtl/lpfc_frame_ctrl.sv]
// Frame state and per-byte decision: length check, byte index, CRC and status.
module lpfc_frame_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       advance_i,
  input  logic [lpfc_pkg::ByteW-1:0] byte_i,
  input  logic [lpfc_pkg::ByteW-1:0] max_len_i,
  output lpfc_pkg::res_t             res_o
);
  import lpfc_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic [ByteW-1:0] frame_len_q, frame_len_d;
  logic [ByteW-1:0] count_q, count_d;
  logic [ByteW-1:0] crc_q, crc_d;
  logic [ByteW-1:0] crc_in;
  logic [ByteW-1:0] crc_next;
  logic             last_byte;

  // A length byte starts the CRC from its initial value.
  assign crc_in = in_frame_q ? crc_q : CrcInit;

  lpfc_crc8 u_crc (
    .crc_i  (crc_in),
    .data_i (byte_i),
    .crc_o  (crc_next)
  );

  assign last_byte = ({1'b0, count_q} + 9'd1) >= {1'b0, frame_len_q};

  // Decide this byte's result and the frame state that follows it.
  always_comb begin
    in_frame_d       = in_frame_q;
    frame_len_d      = frame_len_q;
    count_d          = count_q;
    crc_d            = crc_q;
    res_o.data_byte  = byte_i;
    res_o.byte_index = '0;
    res_o.frame_end  = 1'b0;
    res_o.status     = ST_OK;
    if (!in_frame_q) begin
      if (byte_i < MinFrameLen) begin
        res_o.frame_end = 1'b1;
        res_o.status    = ST_TOO_SHORT;
      end else if (byte_i > max_len_i) begin
        res_o.frame_end = 1'b1;
        res_o.status    = ST_TOO_LONG;
      end else begin
        in_frame_d  = 1'b1;
        frame_len_d = byte_i;
        count_d     = 8'd1;
        crc_d       = crc_next;
      end
    end else begin
      res_o.byte_index = count_q;
      if (last_byte) begin
        res_o.frame_end = 1'b1;
        res_o.status    = (byte_i == crc_q) ? ST_OK : ST_BAD_CRC;
        in_frame_d      = 1'b0;
        frame_len_d     = '0;
        count_d         = '0;
        crc_d           = CrcInit;
      end else begin
        crc_d   = crc_next;
        count_d = count_q + 8'd1;
      end
    end
  end

  // The state moves only when the byte's result is taken into the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      frame_len_q <= '0;
      count_q     <= '0;
      crc_q       <= CrcInit;
    end else if (advance_i) begin
      in_frame_q  <= in_frame_d;
      frame_len_q <= frame_len_d;
      count_q     <= count_d;
      crc_q       <= crc_d;
    end
  end
endmodule

[rtl/length_prefixed_frame_checker_crc8.sv]
// An accepted byte waits in the input register until its result can enter the output register.
// Throughput: one byte per cycle unless the output stalls; the two registers let a new request
// be taken while a result waits, and the per-byte CRC update is shallow unrolled XOR logic.
// Reset (rst_ni, asynchronous, active low): no frame in progress, CRC zero, both pipeline
// registers empty, maximum frame length 20.
module length_prefixed_frame_checker_crc8 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [lpfc_pkg::ByteW-1:0] cfg_wdata_i,
  lpfc_rx_if.sink                    rx_i,
  lpfc_res_if.source                 res_o
);
  import lpfc_pkg::*;

  logic [ByteW-1:0] max_len_q;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             res_valid_q;
  res_t             res_q;
  res_t             res_d;
  logic             res_load;
  logic             in_load;

  // Maximum frame length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxFrameLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // Handshake: the input stage drains into the output register whenever it has room.
  assign res_load   = in_valid_q && (!res_valid_q || res_o.ready);
  assign rx_i.ready = !in_valid_q || res_load;
  assign in_load    = rx_i.valid && rx_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  lpfc_frame_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (res_load),
    .byte_i    (in_byte_q),
    .max_len_i (max_len_q),
    .res_o     (res_d)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_load) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.data_byte  = res_q.data_byte;
  assign res_o.byte_index = res_q.byte_index;
  assign res_o.frame_end  = res_q.frame_end;
  assign res_o.status     = res_q.status;

  // Any error or checksum status closes the frame.
  a_status_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status != ST_OK) |-> res_o.frame_end)
    else $error("nonzero status without frame end");

  // A rejected length byte is always index zero.
  a_len_reject_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && (res_o.status == ST_TOO_SHORT || res_o.status == ST_TOO_LONG)
      |-> res_o.byte_index == '0)
    else $error("length error reported off index zero");

  // With both stages full and the output stalled, no new request is taken.
  a_full_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && res_valid_q && !res_o.ready |-> !rx_i.ready)
    else $error("input ready while pipeline is full and stalled");
endmodule
